// ----- rtl/mcdf_pkg.sv -----
package mcdf_pkg;

   localparam int unsigned QUEUE_DEPTH_DEF = 2;

   localparam logic [31:0] MAX_LEN_RESET = 32'd16777216;
   localparam logic [31:0] MASK_DELTA    = 32'ha282ead8;
   localparam logic [31:0] CRC_POLY      = 32'h82f63b78;
   localparam logic [31:0] CRC_INIT      = 32'hffffffff;

   typedef enum logic [1:0] {
      PH_LEN,
      PH_LCRC,
      PH_PAY,
      PH_PCRC
   } phase_type;

   typedef enum logic [2:0] {
      OP_CRC,
      OP_PAY,
      OP_LCRC_FIN,
      OP_PCRC_FIN,
      OP_END,
      OP_TRUNC
   } op_type;

   typedef enum logic [2:0] {
      KIND_BYTE  = 3'd0,
      KIND_GOOD  = 3'd1,
      KIND_LCRC  = 3'd2,
      KIND_PCRC  = 3'd3,
      KIND_LONG  = 3'd4,
      KIND_TRUNC = 3'd5,
      KIND_END   = 3'd6
   } kind_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  data;
      logic        last;
      logic        too_long;
      logic [31:0] crc_rcv;
      logic [31:0] length;
      logic [47:0] offset;
   } tag_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // Undo the mask: subtract the offset, then rotate left by 15.
   function automatic logic [31:0] unmask_crc(input logic [31:0] masked);
      logic [31:0] r;
      r = masked - MASK_DELTA;
      return {r[16:0], r[31:17]};
   endfunction

endpackage

// ----- rtl/masked_crc32c_record_deframer.sv -----
// Record deframer for a stream of length-prefixed records, each protected by masked CRC32C
// values over its length field and its payload. One byte, or the end-of-stream marker, is
// taken per word; the block sustains one word per clock when the result side keeps up. A
// word passes through front classification into a queue, two words deep by default, then the
// CRC unit, whose result is held in the output register. The per-cycle rate is set by the
// bytewise CRC32C update in the back end. Payload bytes come out as they arrive, the last
// one marked, followed by a record-good word; any CRC error, oversize length, truncation or
// clean end is reported once, after which the block stays silent until reset. The maximum
// record length register may be written whenever the block is idle.
module masked_crc32c_record_deframer
   import mcdf_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_out_kind,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last,
   output logic [31:0] rsp_record_length,
   output logic [47:0] rsp_record_offset,
   output logic [31:0] rsp_records_seen,
   output logic [47:0] rsp_payload_total,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_max_record_length
);

   logic    push;
   tag_type push_tag;
   logic    q_full;
   logic    q_pop;
   logic    q_valid;
   tag_type q_tag;

   mcdf_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_in_byte           (req_in_byte),
      .req_end_of_stream     (req_end_of_stream),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_max_record_length (csr_max_record_length),
      .q_full                (q_full),
      .push                  (push),
      .push_tag              (push_tag)
   );

   mcdf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_tag   (push_tag),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_tag   (q_tag)
   );

   mcdf_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_tag             (q_tag),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_kind      (rsp_out_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_out_last      (rsp_out_last),
      .rsp_record_length (rsp_record_length),
      .rsp_record_offset (rsp_record_offset),
      .rsp_records_seen  (rsp_records_seen),
      .rsp_payload_total (rsp_payload_total)
   );

endmodule

// ----- rtl/mcdf_front.sv -----
module mcdf_front
   import mcdf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_stream,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_max_record_length,
   input  logic        q_full,
   output logic        push,
   output tag_type     push_tag
);

   phase_type   phase_ff, phase_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] len_lo_ff, len_lo_in;
   logic        len_hi_ff, len_hi_in;
   logic [31:0] rcv_ff, rcv_in;
   logic [47:0] pos_ff, pos_in;
   logic [47:0] start_ff, start_in;
   logic        halted_ff, halted_in;
   logic [31:0] max_len_ff;

   logic        step;
   logic        byte_fin;
   logic        len_zero;
   logic        too_long;
   logic [31:0] rcv_next;

   assign req_ready = !q_full;
   assign csr_ready = 1'b1;
   assign step      = req_valid && req_ready && !halted_ff;
   assign byte_fin  = (count_ff[1:0] == 2'd3);
   assign len_zero  = !len_hi_ff && (len_lo_ff == 32'd0);
   assign too_long  = len_hi_ff || (len_lo_ff > max_len_ff);
   assign rcv_next  = {req_in_byte, rcv_ff[31:8]};

   always_comb begin
      phase_in = phase_ff;
      if (step && !req_end_of_stream) begin
         unique case (phase_ff)
            PH_LEN: begin
               if (count_ff[2:0] == 3'd7) phase_in = PH_LCRC;
            end
            PH_LCRC: begin
               if (byte_fin && !too_long) phase_in = len_zero ? PH_PCRC : PH_PAY;
            end
            PH_PAY: begin
               if (count_ff == 32'd1) phase_in = PH_PCRC;
            end
            PH_PCRC: begin
               if (byte_fin) phase_in = PH_LEN;
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   always_comb begin
      count_in  = count_ff;
      len_lo_in = len_lo_ff;
      len_hi_in = len_hi_ff;
      rcv_in    = rcv_ff;
      pos_in    = pos_ff;
      start_in  = start_ff;
      halted_in = halted_ff;
      push      = 1'b0;
      push_tag.op       = OP_CRC;
      push_tag.data     = req_in_byte;
      push_tag.last     = 1'b0;
      push_tag.too_long = too_long;
      push_tag.crc_rcv  = rcv_next;
      push_tag.length   = len_hi_ff ? 32'hffffffff : len_lo_ff;
      push_tag.offset   = start_ff;
      if (step) begin
         if (req_end_of_stream) begin
            halted_in   = 1'b1;
            push        = 1'b1;
            push_tag.op = (phase_ff == PH_LEN && count_ff == 32'd0) ? OP_END : OP_TRUNC;
         end else begin
            pos_in = pos_ff + 48'd1;
            unique case (phase_ff)
               PH_LEN: begin
                  push        = 1'b1;
                  push_tag.op = OP_CRC;
                  if (!count_ff[2]) begin
                     len_lo_in[{count_ff[1:0], 3'b000} +: 8] = req_in_byte;
                  end else if (req_in_byte != 8'd0) begin
                     len_hi_in = 1'b1;
                  end
                  count_in = (count_ff[2:0] == 3'd7) ? 32'd0 : count_ff + 32'd1;
               end
               PH_LCRC: begin
                  rcv_in   = rcv_next;
                  count_in = count_ff + 32'd1;
                  if (byte_fin) begin
                     push        = 1'b1;
                     push_tag.op = OP_LCRC_FIN;
                     if (too_long) begin
                        halted_in = 1'b1;
                     end else begin
                        count_in = len_zero ? 32'd0 : len_lo_ff;
                     end
                  end
               end
               PH_PAY: begin
                  push          = 1'b1;
                  push_tag.op   = OP_PAY;
                  push_tag.last = (count_ff == 32'd1);
                  count_in      = count_ff - 32'd1;
               end
               PH_PCRC: begin
                  rcv_in   = rcv_next;
                  count_in = count_ff + 32'd1;
                  if (byte_fin) begin
                     push        = 1'b1;
                     push_tag.op = OP_PCRC_FIN;
                     count_in    = 32'd0;
                     len_lo_in   = 32'd0;
                     len_hi_in   = 1'b0;
                     start_in    = pos_ff + 48'd1;
                  end
               end
               default: halted_in = halted_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_LEN;
         count_ff   <= 32'd0;
         len_lo_ff  <= 32'd0;
         len_hi_ff  <= 1'b0;
         pos_ff     <= 48'd0;
         start_ff   <= 48'd0;
         halted_ff  <= 1'b0;
         max_len_ff <= MAX_LEN_RESET;
      end else begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         len_lo_ff <= len_lo_in;
         len_hi_ff <= len_hi_in;
         pos_ff    <= pos_in;
         start_ff  <= start_in;
         halted_ff <= halted_in;
         if (csr_valid) begin
            max_len_ff <= csr_max_record_length;
         end
      end
   end

   always_ff @(posedge clock) begin
      rcv_ff <= rcv_in;
   end

endmodule

// ----- rtl/mcdf_queue.sv -----
module mcdf_queue
   import mcdf_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  tag_type push_tag,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output tag_type head_tag
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   tag_type         entry_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_tag   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_tag;
      end
   end

   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue written while full");

   assert property (@(posedge clock) disable iff (reset) pop |-> head_valid)
      else $error("queue read while empty");

endmodule

// ----- rtl/mcdf_back.sv -----
module mcdf_back
   import mcdf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  tag_type     q_tag,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_out_kind,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last,
   output logic [31:0] rsp_record_length,
   output logic [47:0] rsp_record_offset,
   output logic [31:0] rsp_records_seen,
   output logic [47:0] rsp_payload_total
);

   logic [31:0] crc_ff, crc_in;
   logic        halted_ff, halted_in;
   logic [31:0] good_ff, good_in;
   logic [47:0] total_ff, total_in;
   logic        rsp_valid_ff, rsp_valid_in;
   kind_type    kind_ff, kind_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic [31:0] length_ff;
   logic [47:0] offset_ff;
   logic [31:0] seen_ff;
   logic [47:0] sum_ff;

   logic        load;
   logic        crc_ok;

   assign q_pop  = q_valid && (!rsp_valid_ff || rsp_ready);
   assign crc_ok = (unmask_crc(q_tag.crc_rcv) == ~crc_ff);

   always_comb begin
      crc_in    = crc_ff;
      halted_in = halted_ff;
      good_in   = good_ff;
      total_in  = total_ff;
      load      = 1'b0;
      kind_in   = KIND_BYTE;
      byte_in   = 8'd0;
      last_in   = 1'b0;
      if (q_pop && !halted_ff) begin
         unique case (q_tag.op)
            OP_CRC: begin
               crc_in = crc_byte(crc_ff, q_tag.data);
            end
            OP_PAY: begin
               crc_in  = crc_byte(crc_ff, q_tag.data);
               load    = 1'b1;
               kind_in = KIND_BYTE;
               byte_in = q_tag.data;
               last_in = q_tag.last;
            end
            OP_LCRC_FIN: begin
               if (!crc_ok) begin
                  halted_in = 1'b1;
                  load      = 1'b1;
                  kind_in   = KIND_LCRC;
               end else if (q_tag.too_long) begin
                  halted_in = 1'b1;
                  load      = 1'b1;
                  kind_in   = KIND_LONG;
               end else begin
                  crc_in = CRC_INIT;
               end
            end
            OP_PCRC_FIN: begin
               load = 1'b1;
               if (!crc_ok) begin
                  halted_in = 1'b1;
                  kind_in   = KIND_PCRC;
               end else begin
                  good_in  = good_ff + 32'd1;
                  total_in = total_ff + {16'd0, q_tag.length};
                  kind_in  = KIND_GOOD;
                  crc_in   = CRC_INIT;
               end
            end
            OP_END: begin
               halted_in = 1'b1;
               load      = 1'b1;
               kind_in   = KIND_END;
            end
            OP_TRUNC: begin
               halted_in = 1'b1;
               load      = 1'b1;
               kind_in   = KIND_TRUNC;
            end
            default: load = 1'b0;
         endcase
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CRC_INIT;
         halted_ff    <= 1'b0;
         good_ff      <= 32'd0;
         total_ff     <= 48'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         halted_ff    <= halted_in;
         good_ff      <= good_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff   <= kind_in;
         byte_ff   <= byte_in;
         last_ff   <= last_in;
         length_ff <= q_tag.length;
         offset_ff <= q_tag.offset;
         seen_ff   <= good_in;
         sum_ff    <= total_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_kind      = kind_ff;
   assign rsp_out_byte      = byte_ff;
   assign rsp_out_last      = last_ff;
   assign rsp_record_length = length_ff;
   assign rsp_record_offset = offset_ff;
   assign rsp_records_seen  = seen_ff;
   assign rsp_payload_total = sum_ff;

   assert property (@(posedge clock) disable iff (reset)
      (halted_ff && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("word produced after the deframer halted");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff != KIND_BYTE) |-> (byte_ff == 8'd0 && !last_ff))
      else $error("status word carries payload byte data");

   assert property (@(posedge clock) disable iff (reset)
      !$stable(good_ff) |-> (rsp_valid_ff && kind_ff == KIND_GOOD))
      else $error("record count moved without a record-good word");

endmodule
